/* src/ffp_pkg.sv */
// ----------------------------------------------------------------------------
// ffp_pkg: shared types and constants of the frame fragment planner
// Item structs, controller/datapath command and status groups, the CRC-32
// byte update and the framing limits.
// ----------------------------------------------------------------------------
`default_nettype none

package ffp_pkg;

  // framing limits
  localparam int HDR_LEN       = 48;
  localparam int MAX_DATAGRAM  = 1472;
  localparam int MAX_FRAME     = 65536;
  localparam int MAX_FRAGMENTS = 64;

  // field widths
  localparam int LEN_W  = 17;  // frame length, saturates at MAX_FRAME + 1
  localparam int CAP_W  = 11;  // payload capacity per fragment, below 2048
  localparam int IDX_W  = 6;
  localparam int TOT_W  = 7;
  localparam int OFF_W  = 16;
  localparam int DGL_W  = 16;
  localparam int SEQ_W  = 64;
  localparam int CRC_W  = 32;
  localparam int CFG_W  = 64;
  localparam int CFGA_W = 1;

  // configuration register indexes
  localparam logic [CFGA_W-1:0] REG_DATAGRAM_LIMIT = 1'd0;
  localparam logic [CFGA_W-1:0] REG_STREAM_IDENT   = 1'd1;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             end_of_frame;
    logic [SEQ_W-1:0] sequence_number;
  } in_item_t;

  typedef struct packed {
    logic             status;
    logic [SEQ_W-1:0] seq_out;
    logic [LEN_W-1:0] frame_length;
    logic [CRC_W-1:0] frame_crc;
    logic [IDX_W-1:0] fragment_number;
    logic [TOT_W-1:0] fragment_total;
    logic [OFF_W-1:0] fragment_start;
    logic [OFF_W-1:0] fragment_size;
    logic             is_first;
    logic             is_last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic take;       // byte transfer
    logic frame_end;  // transfer carries the final byte
    logic send_err;   // load the refusal result
    logic count_run;  // one fragment-count iteration
    logic emit_run;   // emit one header
  } ffp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic eof;         // final byte on the input
    logic frame_ok;    // config and length pass
    logic count_done;  // remainder fits in one fragment
    logic count_over;  // fragment count would pass the limit
    logic emit_last;   // header being emitted is the final one
  } ffp_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_COUNT = 3'b010,
    ST_EMIT  = 3'b100
  } ffp_state_t;

  // reflected CRC-32 update by one byte, bitwise
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/ffp_ctrl.sv */
// ----------------------------------------------------------------------------
// ffp_ctrl: frame planner controller
// Sequences byte intake, the fragment count iterations and the header burst.
// ----------------------------------------------------------------------------
`default_nettype none

module ffp_ctrl
  import ffp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire ffp_stat_t stat,
  output ffp_cmd_t       cmd
);

  ffp_state_t state_r, state_nxt;

  // commands
  always_comb begin
    cmd           = '0;
    cmd.take      = start && (state_r == ST_IDLE);
    cmd.frame_end = cmd.take && stat.eof;
    cmd.count_run = (state_r == ST_COUNT);
    cmd.emit_run  = (state_r == ST_EMIT);
    cmd.send_err  = (cmd.frame_end && !stat.frame_ok) ||
                    (cmd.count_run && stat.count_over);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.frame_end && stat.frame_ok) state_nxt = ST_COUNT;
      end
      ST_COUNT: begin
        if (stat.count_over)      state_nxt = ST_IDLE;
        else if (stat.count_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.emit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

/* src/ffp_dp.sv */
// ----------------------------------------------------------------------------
// ffp_dp: frame planner datapath
// Config registers, running CRC and byte count, fragment count by repeated
// subtraction, header generation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffp_dp
  import ffp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFGA_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire in_item_t          in_item,
  input  wire ffp_cmd_t          cmd,
  output ffp_stat_t              stat,
  output logic                   out_strobe,
  output out_item_t              out_item
);

  logic [DGL_W-1:0] dgl_r;
  logic [CFG_W-1:0] stream_r;
  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [SEQ_W-1:0] seq_r;
  logic [LEN_W-1:0] len_r;
  logic [CRC_W-1:0] fcrc_r;
  logic [LEN_W-1:0] rem_r;
  logic [CAP_W-1:0] cap_r;
  logic [TOT_W-1:0] tot_r;
  logic [IDX_W-1:0] idx_r;
  logic [LEN_W-1:0] off_r;
  logic             out_strobe_r;
  out_item_t        out_item_r;

  logic [DGL_W-1:0] cap_full;
  logic [LEN_W-1:0] cap_ext;
  logic [LEN_W-1:0] size;
  logic             dgl_ok;
  out_item_t        err_item;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dgl_r    <= DGL_W'(MAX_DATAGRAM);
      stream_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DATAGRAM_LIMIT: dgl_r    <= cfg_wdata[DGL_W-1:0];
        REG_STREAM_IDENT:   stream_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // running CRC and saturating byte count
  always_comb begin
    crc_nxt = crc_byte(crc_r, in_item.data_byte);
    cnt_nxt = (cnt_r <= LEN_W'(MAX_FRAME)) ? cnt_r + 1'b1 : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      cnt_r <= '0;
    end else if (cmd.take) begin
      crc_r <= cmd.frame_end ? CRC_INIT : crc_nxt;
      cnt_r <= cmd.frame_end ? '0 : cnt_nxt;
    end
  end

  // frame checks on the final byte
  assign cap_full = dgl_r - DGL_W'(HDR_LEN);
  assign dgl_ok   = (dgl_r > DGL_W'(HDR_LEN)) && (dgl_r <= DGL_W'(MAX_DATAGRAM));
  assign cap_ext  = {{(LEN_W-CAP_W){1'b0}}, cap_r};
  assign size     = (rem_r < cap_ext) ? rem_r : cap_ext;

  always_comb begin
    stat            = '0;
    stat.eof        = in_item.end_of_frame;
    stat.frame_ok   = (stream_r != '0) && dgl_ok && (cnt_nxt <= LEN_W'(MAX_FRAME));
    stat.count_done = (rem_r <= cap_ext);
    stat.count_over = !stat.count_done && (tot_r == TOT_W'(MAX_FRAGMENTS));
    stat.emit_last  = ({1'b0, idx_r} == (tot_r - 1'b1));
  end

  // frame capture, fragment count and header walk
  always_ff @(posedge clk) begin
    if (cmd.frame_end) begin
      seq_r  <= in_item.sequence_number;
      len_r  <= cnt_nxt;
      fcrc_r <= ~crc_nxt;
      rem_r  <= cnt_nxt;
      cap_r  <= cap_full[CAP_W-1:0];
      tot_r  <= TOT_W'(1);
    end else if (cmd.count_run) begin
      if (stat.count_done) begin
        rem_r <= len_r;
        off_r <= '0;
        idx_r <= '0;
      end else begin
        rem_r <= rem_r - cap_ext;
        tot_r <= tot_r + 1'b1;
      end
    end else if (cmd.emit_run) begin
      rem_r <= rem_r - cap_ext;
      off_r <= off_r + cap_ext;
      idx_r <= idx_r + 1'b1;
    end
  end

  // refusal result: only status and last mark set
  always_comb begin
    err_item         = '0;
    err_item.status  = 1'b1;
    err_item.is_last = 1'b1;
  end

  // result register: one strobe per result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.send_err || cmd.emit_run;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send_err) begin
      out_item_r <= err_item;
    end else if (cmd.emit_run) begin
      out_item_r.status          <= 1'b0;
      out_item_r.seq_out         <= seq_r;
      out_item_r.frame_length    <= len_r;
      out_item_r.frame_crc       <= fcrc_r;
      out_item_r.fragment_number <= idx_r;
      out_item_r.fragment_total  <= tot_r;
      out_item_r.fragment_start  <= off_r[OFF_W-1:0];
      out_item_r.fragment_size   <= size[OFF_W-1:0];
      out_item_r.is_first        <= (idx_r == '0);
      out_item_r.is_last         <= stat.emit_last;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

`default_nettype wire

/* src/frame_fragment_planner_crc.sv */
// Non-final bytes: one transfer per cycle, busy stays low, no result.
// Final byte: fragments are counted in the count state by repeated subtraction of the
// capacity, then the emit state gives one header per fragment on consecutive cycles;
// busy is high in both states. A frame refused on settings or length gives its error
// result the next cycle; one needing more than 64 fragments once the count reaches 64.
// Receiver cannot stall. Sync reset: datagram limit 1472, stream id 0, CRC all ones.
// ----------------------------------------------------------------------------
// frame_fragment_planner_crc: top level
// Byte-wide CRC-32 frame intake with per-fragment header planning.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_fragment_planner_crc
  import ffp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFGA_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          in_item,
  output logic                   out_strobe,
  output out_item_t              out_item
);

  ffp_cmd_t  cmd;
  ffp_stat_t stat;

  ffp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ffp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

/* test/fragment_header_checker.sv */
// ----------------------------------------------------------------------------
// fragment_header_checker: header prediction and compare
// Watches register writes, byte transfers and result strobes of the frame
// fragment planner, predicts each header or refusal and checks every field.
// ----------------------------------------------------------------------------
module fragment_header_checker
  import ffp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFGA_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              start,
  input  logic              busy,
  input  in_item_t          in_item,
  input  logic              out_strobe,
  input  out_item_t         out_item,
  output int                errors_seen,
  output int                expected_left,
  output int                results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] FRAME_POLY = 32'hEDB8_8320;

  // register shadow and running frame state
  logic [DGL_W-1:0] dgram_limit;
  logic [SEQ_W-1:0] sid_shadow;
  logic [CRC_W-1:0] frame_crc_acc;
  int               byte_tally;
  out_item_t        header_queue[$];

  // reflected CRC-32, one bit per pass
  function automatic logic [31:0] crc_step(logic [31:0] acc, logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (FRAME_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors_seen++;
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // oldest expectation against the result on the ports
  task automatic compare_header(out_item_t got);
    out_item_t want;
    if (header_queue.size() == 0) begin
      errors_seen++;
      $display("%0t ns: result with none expected, expected nothing actual %h",
               $time, got);
    end else begin
      want = header_queue.pop_front();
      results_checked++;
      check_field("status", want.status, got.status);
      check_field("seq_out", want.seq_out, got.seq_out);
      check_field("frame_length", want.frame_length, got.frame_length);
      check_field("frame_crc", want.frame_crc, got.frame_crc);
      check_field("fragment_number", want.fragment_number, got.fragment_number);
      check_field("fragment_total", want.fragment_total, got.fragment_total);
      check_field("fragment_start", want.fragment_start, got.fragment_start);
      check_field("fragment_size", want.fragment_size, got.fragment_size);
      check_field("is_first", want.is_first, got.is_first);
      check_field("is_last", want.is_last, got.is_last);
    end
  endtask

  // fold one byte in; on the final byte plan the fragment headers
  task automatic plan_fragments(in_item_t it);
    int        cap;
    int        total;
    int        offset;
    int        frag_len;
    out_item_t h;
    frame_crc_acc = crc_step(frame_crc_acc, it.data_byte);
    if (byte_tally <= MAX_FRAME) byte_tally++;
    if (it.end_of_frame) begin
      cap   = 0;
      total = 0;
      if (int'(dgram_limit) > HDR_LEN && int'(dgram_limit) <= MAX_DATAGRAM &&
          byte_tally <= MAX_FRAME) begin
        cap   = int'(dgram_limit) - HDR_LEN;
        total = (byte_tally + cap - 1) / cap;
      end
      if (sid_shadow == '0 || total == 0 || total > MAX_FRAGMENTS) begin
        // refusal: single result, only status and last mark set
        h         = '0;
        h.status  = 1'b1;
        h.is_last = 1'b1;
        header_queue.push_back(h);
      end else begin
        for (int i = 0; i < total; i++) begin
          offset   = i * cap;
          frag_len = (byte_tally - offset < cap) ? byte_tally - offset : cap;
          h                 = '0;
          h.seq_out         = it.sequence_number;
          h.frame_length    = LEN_W'(byte_tally);
          h.frame_crc       = ~frame_crc_acc;
          h.fragment_number = IDX_W'(i);
          h.fragment_total  = TOT_W'(total);
          h.fragment_start  = OFF_W'(offset);
          h.fragment_size   = OFF_W'(frag_len);
          h.is_first        = (i == 0);
          h.is_last         = (i == total - 1);
          header_queue.push_back(h);
        end
      end
      frame_crc_acc = CRC_INIT;
      byte_tally    = 0;
    end
  endtask

  // results first, then register writes, then the byte transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      dgram_limit     = DGL_W'(MAX_DATAGRAM);
      sid_shadow      = '0;
      frame_crc_acc   = CRC_INIT;
      byte_tally      = 0;
      errors_seen     = 0;
      results_checked = 0;
      header_queue.delete();
    end else begin
      if (out_strobe) compare_header(out_item);
      if (cfg_we) begin
        if (cfg_index == REG_DATAGRAM_LIMIT) dgram_limit = cfg_wdata[DGL_W-1:0];
        else if (cfg_index == REG_STREAM_IDENT) sid_shadow = cfg_wdata;
      end
      if (start && !busy) plan_fragments(in_item);
    end
    expected_left = header_queue.size();
  end

endmodule

/* test/frame_fragment_planner_crc_tb.sv */
// ----------------------------------------------------------------------------
// frame_fragment_planner_crc_tb: testbench top
// Drives frames byte by byte with random gaps, sweeps the datagram limit and
// stream id through legal, edge and refused values, and reports the verdict.
// ----------------------------------------------------------------------------
module frame_fragment_planner_crc_tb;
  import ffp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 150;
  localparam int SETTLE_PAD   = 4;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CFGA_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              start;
  logic              busy;
  in_item_t          in_item;
  logic              out_strobe;
  out_item_t         out_item;

  int errors_seen;
  int expected_left;
  int results_checked;
  int frames_sent   = 0;
  int bytes_sent    = 0;
  int settings_used = 0;

  always #1 clk = ~clk;

  frame_fragment_planner_crc DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  fragment_header_checker header_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .busy            (busy),
    .in_item         (in_item),
    .out_strobe      (out_strobe),
    .out_item        (out_item),
    .errors_seen     (errors_seen),
    .expected_left   (expected_left),
    .results_checked (results_checked)
  );

  // one byte transfer; returns at the edge that takes it
  task automatic send_byte(logic [7:0] b, logic eof, logic [SEQ_W-1:0] seq, int gap);
    in_item_t it;
    it.data_byte       = b;
    it.end_of_frame    = eof;
    it.sequence_number = seq;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    bytes_sent++;
    if (eof) frames_sent++;
  endtask

  // frame of random bytes, final byte carries a random sequence number
  task automatic send_frame(int len, int gap_max);
    for (int i = 0; i < len; i++) begin
      send_byte($urandom(), (i == len - 1), {$urandom(), $urandom()},
                $urandom_range(0, gap_max));
    end
  endtask

  // drain all expected results, then let the block settle
  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (expected_left != 0 || busy);
    repeat (SETTLE_PAD) @(posedge clk);
  endtask

  // both registers back to back; upper data bits of the limit write are noise
  task automatic write_config(logic [DGL_W-1:0] dl, logic [SEQ_W-1:0] sid);
    logic [CFG_W-1:0] wd;
    wd        = {$urandom(), $urandom()};
    wd[15:0]  = dl;
    cfg_we    <= 1'b1;
    cfg_index <= REG_DATAGRAM_LIMIT;
    cfg_wdata <= wd;
    @(posedge clk);
    cfg_index <= REG_STREAM_IDENT;
    cfg_wdata <= sid;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // run limit
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    string            check_str;
    int               random_bytes;
    int               gap_max;
    int               len;
    logic [DGL_W-1:0] dl;
    logic [SEQ_W-1:0] sid;

    check_str    = "123456789";
    random_bytes = 0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    start     <= 1'b0;
    in_item   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: zero stream id refuses the frame
    send_byte(8'h00, 1'b1, '0, 0);
    wait_idle();

    // widest stream id, largest legal datagram, known check string
    write_config(DGL_W'(MAX_DATAGRAM), '1);
    for (int i = 0; i < check_str.len(); i++) begin
      send_byte(check_str[i], (i == check_str.len() - 1), '1, i % 3);
    end
    send_byte(8'hFF, 1'b1, '0, 2);
    wait_idle();

    // smallest capacity: one byte per fragment
    write_config(DGL_W'(HDR_LEN + 1), 64'h5A5A_0F0F_3C3C_C3C3);
    send_frame(3, 0);
    wait_idle();

    // datagram limit out of range, both sides and both extremes
    write_config(DGL_W'(HDR_LEN), 64'd7);
    send_frame(1, 0);
    wait_idle();
    write_config(DGL_W'(MAX_DATAGRAM + 1), 64'd7);
    send_frame(1, 1);
    wait_idle();
    write_config('0, 64'd7);
    send_frame(1, 0);
    wait_idle();
    write_config('1, 64'd7);
    send_frame(1, 0);
    wait_idle();

    // two-byte capacity: even split and a short last fragment
    write_config(DGL_W'(HDR_LEN + 2), 64'd9);
    send_frame(4, 3);
    send_frame(5, 0);
    wait_idle();

    // most fragments at one byte each, then one fragment too many
    write_config(DGL_W'(HDR_LEN + 1), 64'd1);
    send_frame(MAX_FRAGMENTS, 0);
    send_frame(MAX_FRAGMENTS + 1, 0);
    wait_idle();

    // random settings, mostly small capacities so frames split often
    while (random_bytes < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        0:       dl = DGL_W'($urandom());
        1:       dl = $urandom_range(0, 1) ? DGL_W'(HDR_LEN)
                                           : DGL_W'(MAX_DATAGRAM + 1);
        2, 3:    dl = DGL_W'($urandom_range(1072, MAX_DATAGRAM));
        default: dl = DGL_W'($urandom_range(HDR_LEN + 1, HDR_LEN + 8));
      endcase
      sid = ($urandom_range(0, 7) == 0) ? '0 : {$urandom(), $urandom()};
      write_config(dl, sid);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
      repeat ($urandom_range(2, 6)) begin
        if (random_bytes < RANDOM_BYTES) begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70)
                                            : $urandom_range(1, 24);
          send_frame(len, gap_max);
          random_bytes += len;
        end
      end
      wait_idle();
    end

    $display("Covered %0d frames, %0d bytes, %0d register settings", frames_sent,
             bytes_sent, settings_used);
    $display("Checked %0d headers and refusals", results_checked);
    if (errors_seen == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
